// ===== rtl/arp_pkg.sv =====
`timescale 1ns / 1ps

package arp_pkg;

   localparam int CORDIC_STEPS = 16;   // range 8 .. 24
   localparam int ATAN_ENTRIES = 24;

   localparam int COORD_W = 24;
   localparam int ANGLE_W = 16;
   localparam int RAD_W   = 16;
   localparam int HD_W    = 16;
   localparam int IDX_W   = 2;
   localparam int STEP_W  = 5;
   localparam int TRIG_W  = 32;        // Q30 trig and Q29 angle share this width
   localparam int TRIG_FRAC = 30;
   localparam int PROD_W  = RAD_W + 1 + TRIG_W;
   localparam int SCL_W   = PROD_W + 1 - TRIG_FRAC;
   localparam int SUM_W   = COORD_W + 2;
   localparam int ARMORS  = 4;

   localparam logic signed [TRIG_W-1:0] PI_Q29      = 32'sd1686629713;
   localparam logic signed [TRIG_W-1:0] HALF_PI_Q29 = 32'sd843314857;
   localparam logic signed [TRIG_W-1:0] GAIN_Q30    = 32'sd652032874;
   localparam logic signed [PROD_W:0]   ROUND_BIAS  = 50'sd536870912;

   localparam logic signed [SUM_W-1:0] COORD_MAX = 26'sd8388607;
   localparam logic signed [SUM_W-1:0] COORD_MIN = -26'sd8388608;

   localparam logic [IDX_W-1:0] FIRST_IDX = 2'd0;
   localparam logic [IDX_W-1:0] LAST_IDX  = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [RAD_W-1:0]          rh;
      logic [RAD_W-1:0]          rl;
      logic signed [HD_W-1:0]    hd;
      logic                      hi;
      logic                      flip;
   } side_type;

   typedef struct packed {
      logic [ARMORS-1:0][COORD_W-1:0] ax;
      logic [ARMORS-1:0][COORD_W-1:0] az;
      logic [COORD_W-1:0]             y_even;
      logic [COORD_W-1:0]             y_odd;
   } armor_set_type;

   function automatic logic signed [TRIG_W-1:0] atan_q29(input logic [STEP_W-1:0] i);
      logic signed [TRIG_W-1:0] r;
      case (i)
         5'd0:    r = 32'sd421657428;
         5'd1:    r = 32'sd248918915;
         5'd2:    r = 32'sd131521918;
         5'd3:    r = 32'sd66762579;
         5'd4:    r = 32'sd33510843;
         5'd5:    r = 32'sd16771758;
         5'd6:    r = 32'sd8387925;
         5'd7:    r = 32'sd4194219;
         5'd8:    r = 32'sd2097141;
         5'd9:    r = 32'sd1048575;
         5'd10:   r = 32'sd524288;
         5'd11:   r = 32'sd262144;
         5'd12:   r = 32'sd131072;
         5'd13:   r = 32'sd65536;
         5'd14:   r = 32'sd32768;
         5'd15:   r = 32'sd16384;
         5'd16:   r = 32'sd8192;
         5'd17:   r = 32'sd4096;
         5'd18:   r = 32'sd2048;
         5'd19:   r = 32'sd1024;
         5'd20:   r = 32'sd512;
         5'd21:   r = 32'sd256;
         5'd22:   r = 32'sd128;
         5'd23:   r = 32'sd64;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   // floor((p + 2^29) / 2^30)
   function automatic logic signed [SCL_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W:0] s;
      s = (PROD_W+1)'(p) + ROUND_BIAS;
      return s[PROD_W:TRIG_FRAC];
   endfunction

   function automatic logic [COORD_W-1:0] sat_add(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [SCL_W-1:0] b,
                                                  input logic sub);
      logic signed [SUM_W-1:0] s;
      s = sub ? (SUM_W'(a) - SUM_W'(b)) : (SUM_W'(a) + SUM_W'(b));
      if (s > COORD_MAX) begin
         s = COORD_MAX;
      end else if (s < COORD_MIN) begin
         s = COORD_MIN;
      end
      return s[COORD_W-1:0];
   endfunction

endpackage

// ===== rtl/arp_cordic_stage.sv =====
`timescale 1ns / 1ps

module arp_cordic_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic [arp_pkg::STEP_W-1:0]          step,
   input  logic                                in_valid,
   input  logic signed [arp_pkg::TRIG_W-1:0]   in_x,
   input  logic signed [arp_pkg::TRIG_W-1:0]   in_y,
   input  logic signed [arp_pkg::TRIG_W-1:0]   in_z,
   input  arp_pkg::side_type                   in_side,
   output logic                                out_valid,
   output logic signed [arp_pkg::TRIG_W-1:0]   out_x,
   output logic signed [arp_pkg::TRIG_W-1:0]   out_y,
   output logic signed [arp_pkg::TRIG_W-1:0]   out_z,
   output arp_pkg::side_type                   out_side
);
   import arp_pkg::*;

   logic                     valid_ff;
   logic signed [TRIG_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic signed [TRIG_W-1:0] x_sh, y_sh, atan;
   side_type                 side_ff;

   assign x_sh = in_x >>> step;
   assign y_sh = in_y >>> step;
   assign atan = atan_q29(step);

   // zero angle rotates the positive way
   always_comb begin
      if (!in_z[TRIG_W-1]) begin
         x_in = in_x - y_sh;
         y_in = in_y + x_sh;
         z_in = in_z - atan;
      end else begin
         x_in = in_x + y_sh;
         y_in = in_y - x_sh;
         z_in = in_z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/arp_scale.sv =====
`timescale 1ns / 1ps

module arp_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [arp_pkg::TRIG_W-1:0]   in_cos,
   input  logic signed [arp_pkg::TRIG_W-1:0]   in_sin,
   input  arp_pkg::side_type                   in_side,
   output logic                                out_valid,
   output arp_pkg::armor_set_type              out_set
);
   import arp_pkg::*;

   // stage a: half-turn flip, radius choice
   logic                     a_valid_ff;
   logic signed [TRIG_W-1:0] a_cos_ff, a_sin_ff;
   logic [RAD_W-1:0]         a_rnow_ff, a_rnext_ff;
   side_type                 a_side_ff;
   // stage b: products
   logic                     b_valid_ff;
   logic signed [PROD_W-1:0] b_ns_ff, b_nc_ff, b_xs_ff, b_xc_ff;
   logic signed [PROD_W-1:0] b_ns_in, b_nc_in, b_xs_in, b_xc_in;
   side_type                 b_side_ff;
   // stage c: rounded offsets
   logic                     c_valid_ff;
   logic signed [SCL_W-1:0]  c_ns_ff, c_nc_ff, c_xs_ff, c_xc_ff;
   side_type                 c_side_ff;
   // stage d: saturated positions
   logic                     d_valid_ff;
   armor_set_type            d_set_ff, d_set_in;
   logic [COORD_W-1:0]       y_low;

   assign b_ns_in = $signed({1'b0, a_rnow_ff})  * a_sin_ff;
   assign b_nc_in = $signed({1'b0, a_rnow_ff})  * a_cos_ff;
   assign b_xs_in = $signed({1'b0, a_rnext_ff}) * a_sin_ff;
   assign b_xc_in = $signed({1'b0, a_rnext_ff}) * a_cos_ff;

   assign y_low = sat_add(c_side_ff.cy, SCL_W'(c_side_ff.hd), 1'b1);

   always_comb begin
      d_set_in.ax[0]  = sat_add(c_side_ff.cx, c_ns_ff, 1'b0);
      d_set_in.az[0]  = sat_add(c_side_ff.cz, c_nc_ff, 1'b1);
      d_set_in.ax[1]  = sat_add(c_side_ff.cx, c_xc_ff, 1'b0);
      d_set_in.az[1]  = sat_add(c_side_ff.cz, c_xs_ff, 1'b0);
      d_set_in.ax[2]  = sat_add(c_side_ff.cx, c_ns_ff, 1'b1);
      d_set_in.az[2]  = sat_add(c_side_ff.cz, c_nc_ff, 1'b0);
      d_set_in.ax[3]  = sat_add(c_side_ff.cx, c_xc_ff, 1'b1);
      d_set_in.az[3]  = sat_add(c_side_ff.cz, c_xs_ff, 1'b1);
      d_set_in.y_even = c_side_ff.hi ? c_side_ff.cy : y_low;
      d_set_in.y_odd  = c_side_ff.hi ? y_low : c_side_ff.cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_cos_ff   <= in_side.flip ? -in_cos : in_cos;
         a_sin_ff   <= in_side.flip ? -in_sin : in_sin;
         a_rnow_ff  <= in_side.hi ? in_side.rh : in_side.rl;
         a_rnext_ff <= in_side.hi ? in_side.rl : in_side.rh;
         a_side_ff  <= in_side;

         b_ns_ff    <= b_ns_in;
         b_nc_ff    <= b_nc_in;
         b_xs_ff    <= b_xs_in;
         b_xc_ff    <= b_xc_in;
         b_side_ff  <= a_side_ff;

         c_ns_ff    <= round_q30(b_ns_ff);
         c_nc_ff    <= round_q30(b_nc_ff);
         c_xs_ff    <= round_q30(b_xs_ff);
         c_xc_ff    <= round_q30(b_xc_ff);
         c_side_ff  <= b_side_ff;

         d_set_ff   <= d_set_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_set   = d_set_ff;

endmodule

// ===== rtl/arp_serializer.sv =====
`timescale 1ns / 1ps

module arp_serializer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  arp_pkg::armor_set_type             in_set,
   output logic                               pipe_en,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [arp_pkg::IDX_W-1:0]          rsp_armor_index,
   output logic [arp_pkg::COORD_W-1:0]        rsp_armor_x,
   output logic [arp_pkg::COORD_W-1:0]        rsp_armor_y,
   output logic [arp_pkg::COORD_W-1:0]        rsp_armor_z,
   output logic                               rsp_last_armor
);
   import arp_pkg::*;

   logic               valid_ff, valid_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   armor_set_type      set_ff, set_in;
   logic               taken, done, load;

   assign taken   = valid_ff && !rsp_stall;
   assign done    = taken && (idx_ff == LAST_IDX);
   assign pipe_en = !valid_ff || done;
   assign load    = pipe_en && in_valid;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      set_in   = set_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = FIRST_IDX;
         set_in   = in_set;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (taken) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= FIRST_IDX;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff <= set_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_armor_index = idx_ff;
   assign rsp_armor_x     = set_ff.ax[idx_ff];
   assign rsp_armor_z     = set_ff.az[idx_ff];
   assign rsp_armor_y     = idx_ff[0] ? set_ff.y_odd : set_ff.y_even;
   assign rsp_last_armor  = (idx_ff == LAST_IDX);

endmodule

// ===== rtl/armor_ring_positions.sv =====
`timescale 1ns / 1ps

// Four armor positions around a vehicle centre, in ring order, one armor per
// result item. Each request item passes an entry stage (half-turn reduction of
// the angle), one pipeline stage per CORDIC step (CORDIC_STEPS, 16 here), then
// flip/radius select, multiply, round and add/saturate stages. The single
// result register hands out the four armors of an item one after another, as
// each is taken, so a new request is taken only when the register is empty or
// its last armor is taken. The whole pipeline holds while the result register
// still has armors to give.

module armor_ring_positions (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [arp_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [arp_pkg::COORD_W-1:0] req_center_y,
   input  logic signed [arp_pkg::COORD_W-1:0] req_center_z,
   input  logic signed [arp_pkg::ANGLE_W-1:0] req_facing_angle,
   input  logic [arp_pkg::RAD_W-1:0]          req_high_radius,
   input  logic [arp_pkg::RAD_W-1:0]          req_low_radius,
   input  logic signed [arp_pkg::HD_W-1:0]    req_height_difference,
   input  logic                               req_facing_is_high,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [arp_pkg::IDX_W-1:0]          rsp_armor_index,
   output logic signed [arp_pkg::COORD_W-1:0] rsp_armor_x,
   output logic signed [arp_pkg::COORD_W-1:0] rsp_armor_y,
   output logic signed [arp_pkg::COORD_W-1:0] rsp_armor_z,
   output logic                               rsp_last_armor
);
   import arp_pkg::*;

   logic                     pipe_en;
   logic signed [TRIG_W-1:0] z_wide, z_in;
   logic                     flip_in;
   side_type                 side_in;

   logic [CORDIC_STEPS:0]    cv;
   logic signed [TRIG_W-1:0] cx_w [CORDIC_STEPS+1];
   logic signed [TRIG_W-1:0] cy_w [CORDIC_STEPS+1];
   logic signed [TRIG_W-1:0] cz_w [CORDIC_STEPS+1];
   side_type                 cs_w [CORDIC_STEPS+1];

   logic                     s0_valid_ff;
   logic signed [TRIG_W-1:0] s0_z_ff;
   side_type                 s0_side_ff;

   logic                     set_valid;
   armor_set_type            set_w;
   logic [COORD_W-1:0]       ax_u, ay_u, az_u;

   assign req_stall = !pipe_en;

   // angle to Q29, fold into plus or minus half pi
   assign z_wide = {req_facing_angle, 16'd0};
   always_comb begin
      z_in    = z_wide;
      flip_in = 1'b0;
      if (z_wide > HALF_PI_Q29) begin
         z_in    = z_wide - PI_Q29;
         flip_in = 1'b1;
      end else if (z_wide < -HALF_PI_Q29) begin
         z_in    = z_wide + PI_Q29;
         flip_in = 1'b1;
      end
      side_in.cx   = req_center_x;
      side_in.cy   = req_center_y;
      side_in.cz   = req_center_z;
      side_in.rh   = req_high_radius;
      side_in.rl   = req_low_radius;
      side_in.hd   = req_height_difference;
      side_in.hi   = req_facing_is_high;
      side_in.flip = flip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_z_ff    <= z_in;
         s0_side_ff <= side_in;
      end
   end

   assign cv[0]   = s0_valid_ff;
   assign cx_w[0] = GAIN_Q30;
   assign cy_w[0] = '0;
   assign cz_w[0] = s0_z_ff;
   assign cs_w[0] = s0_side_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      arp_cordic_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (pipe_en),
         .step      (STEP_W'(k)),
         .in_valid  (cv[k]),
         .in_x      (cx_w[k]),
         .in_y      (cy_w[k]),
         .in_z      (cz_w[k]),
         .in_side   (cs_w[k]),
         .out_valid (cv[k+1]),
         .out_x     (cx_w[k+1]),
         .out_y     (cy_w[k+1]),
         .out_z     (cz_w[k+1]),
         .out_side  (cs_w[k+1])
      );
   end

   arp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (cv[CORDIC_STEPS]),
      .in_cos    (cx_w[CORDIC_STEPS]),
      .in_sin    (cy_w[CORDIC_STEPS]),
      .in_side   (cs_w[CORDIC_STEPS]),
      .out_valid (set_valid),
      .out_set   (set_w)
   );

   arp_serializer u_ser (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (set_valid),
      .in_set          (set_w),
      .pipe_en         (pipe_en),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_armor_index (rsp_armor_index),
      .rsp_armor_x     (ax_u),
      .rsp_armor_y     (ay_u),
      .rsp_armor_z     (az_u),
      .rsp_last_armor  (rsp_last_armor)
   );

   assign rsp_armor_x = $signed(ax_u);
   assign rsp_armor_y = $signed(ay_u);
   assign rsp_armor_z = $signed(az_u);

   // a taken armor that is not the last is followed at once by the next one
   a_ring_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_armor |=>
         rsp_valid && rsp_armor_index == $past(rsp_armor_index) + IDX_W'(1))
      else $error("armor ring order broken");

   // requests are held back only while the result register is occupied
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && (rsp_stall || !rsp_last_armor))
      else $error("request stalled without cause");

   // a frozen pipeline keeps its items
   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(cv) && $stable(set_valid))
      else $error("pipeline moved while held");

endmodule

// ===== sim/armor_ring_checker.sv =====
`timescale 1ns / 1ps

module armor_ring_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic signed [arp_pkg::COORD_W-1:0] req_center_x,
   input  logic signed [arp_pkg::COORD_W-1:0] req_center_y,
   input  logic signed [arp_pkg::COORD_W-1:0] req_center_z,
   input  logic signed [arp_pkg::ANGLE_W-1:0] req_facing_angle,
   input  logic [arp_pkg::RAD_W-1:0]          req_high_radius,
   input  logic [arp_pkg::RAD_W-1:0]          req_low_radius,
   input  logic signed [arp_pkg::HD_W-1:0]    req_height_difference,
   input  logic                               req_facing_is_high,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [arp_pkg::IDX_W-1:0]          rsp_armor_index,
   input  logic signed [arp_pkg::COORD_W-1:0] rsp_armor_x,
   input  logic signed [arp_pkg::COORD_W-1:0] rsp_armor_y,
   input  logic signed [arp_pkg::COORD_W-1:0] rsp_armor_z,
   input  logic                               rsp_last_armor,
   output int                                 mismatches,
   output int                                 outstanding,
   output int                                 armors_checked,
   output int                                 clamped_coords
);
   import arp_pkg::*;

   localparam longint HALF_TURN    = 64'sd1686629713;   // pi in Q29
   localparam longint QUARTER_TURN = 64'sd843314857;    // pi/2 in Q29
   localparam longint CORDIC_GAIN  = 64'sd652032874;    // Q30
   localparam longint COORD_HI     = 64'sd8388607;
   localparam longint COORD_LO     = -64'sd8388608;
   localparam int     TABLE_STEPS  = 24;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               last;
   } armor_pos_type;

   armor_pos_type armors_due [$];

   initial begin
      mismatches     = 0;
      outstanding    = 0;
      armors_checked = 0;
      clamped_coords = 0;
   end

   // atan(2^-i) in Q29; from step 10 on it is exactly 2^(29-i)
   function automatic longint arctan_q29(input int step);
      case (step)
         0:       return 64'sd421657428;
         1:       return 64'sd248918915;
         2:       return 64'sd131521918;
         3:       return 64'sd66762579;
         4:       return 64'sd33510843;
         5:       return 64'sd16771758;
         6:       return 64'sd8387925;
         7:       return 64'sd4194219;
         8:       return 64'sd2097141;
         9:       return 64'sd1048575;
         default: return longint'(1) << (29 - step);
      endcase
   endfunction

   function automatic void sin_cos_q30(input longint angle_q13, output longint sin_q30,
                                       output longint cos_q30);
      longint z;
      longint x;
      longint y;
      longint nx;
      bit     flip;
      int     step;
      z    = angle_q13 * 65536;
      x    = CORDIC_GAIN;
      y    = 0;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
         z    = z - HALF_TURN;
         flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
         z    = z + HALF_TURN;
         flip = 1'b1;
      end
      for (step = 0; step < CORDIC_STEPS && step < TABLE_STEPS; step++) begin
         if (z >= 0) begin
            nx = x - (y >>> step);
            y  = y + (x >>> step);
            z  = z - arctan_q29(step);
         end else begin
            nx = x + (y >>> step);
            y  = y - (x >>> step);
            z  = z + arctan_q29(step);
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      sin_q30 = y;
      cos_q30 = x;
   endfunction

   // Q8 radius times Q30 trig, rounded half up back to Q8
   function automatic longint radius_times(input longint radius, input longint trig);
      return (radius * trig + (longint'(1) << 29)) >>> 30;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
      if (v > COORD_HI) begin
         clamped_coords++;
         return COORD_HI[COORD_W-1:0];
      end else if (v < COORD_LO) begin
         clamped_coords++;
         return COORD_LO[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic void predict_ring();
      longint        cx;
      longint        cy;
      longint        cz;
      longint        hd;
      longint        r_now;
      longint        r_next;
      longint        s;
      longint        c;
      longint        now_s;
      longint        now_c;
      longint        next_s;
      longint        next_c;
      longint        y_even;
      longint        y_odd;
      longint        ax [ARMORS];
      longint        az [ARMORS];
      armor_pos_type a;
      cx     = req_center_x;
      cy     = req_center_y;
      cz     = req_center_z;
      hd     = req_height_difference;
      r_now  = req_facing_is_high ? req_high_radius : req_low_radius;
      r_next = req_facing_is_high ? req_low_radius : req_high_radius;
      sin_cos_q30(longint'(req_facing_angle), s, c);
      now_s  = radius_times(r_now, s);
      now_c  = radius_times(r_now, c);
      next_s = radius_times(r_next, s);
      next_c = radius_times(r_next, c);
      // ring order: minus current, plus next, plus current, minus next
      ax[0] = cx + now_s;   az[0] = cz - now_c;
      ax[1] = cx + next_c;  az[1] = cz + next_s;
      ax[2] = cx - now_s;   az[2] = cz + now_c;
      ax[3] = cx - next_c;  az[3] = cz - next_s;
      y_even = req_facing_is_high ? cy : cy - hd;
      y_odd  = req_facing_is_high ? cy - hd : cy;
      for (int k = 0; k < ARMORS; k++) begin
         a.idx  = k[IDX_W-1:0];
         a.x    = clamp_coord(ax[k]);
         a.y    = clamp_coord((k % 2 == 1) ? y_odd : y_even);
         a.z    = clamp_coord(az[k]);
         a.last = (k == ARMORS - 1);
         armors_due.push_back(a);
      end
   endfunction

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_armor();
      armor_pos_type want;
      armors_checked++;
      if (armors_due.size() == 0) begin
         report($sformatf("armor %0d arrived with nothing outstanding", rsp_armor_index));
      end else begin
         want = armors_due.pop_front();
         if (rsp_armor_index !== want.idx)
            report($sformatf("index: got %0d, expected %0d", rsp_armor_index, want.idx));
         if (rsp_armor_x !== want.x)
            report($sformatf("armor %0d x: got %0d, expected %0d", want.idx,
                             rsp_armor_x, $signed(want.x)));
         if (rsp_armor_y !== want.y)
            report($sformatf("armor %0d y: got %0d, expected %0d", want.idx,
                             rsp_armor_y, $signed(want.y)));
         if (rsp_armor_z !== want.z)
            report($sformatf("armor %0d z: got %0d, expected %0d", want.idx,
                             rsp_armor_z, $signed(want.z)));
         if (rsp_last_armor !== want.last)
            report($sformatf("armor %0d last flag: got %b, expected %b", want.idx,
                             rsp_last_armor, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         armors_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_armor();
         if (req_valid && !req_stall) predict_ring();
      end
      outstanding <= armors_due.size();
   end

endmodule

// ===== sim/tb_armor_ring_positions.sv =====
`timescale 1ns / 1ps

module tb_armor_ring_positions;
   import arp_pkg::*;

   localparam int RANDOM_REQS  = 310;
   localparam int PIPE_LATENCY = 1 + CORDIC_STEPS + 5;
   localparam int HOLD_CYCLES  = 300;
   localparam int BURST_REQS   = 40;

   localparam logic signed [COORD_W-1:0] COORD_TOP    = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_BOTTOM = 24'sh800000;
   localparam logic signed [ANGLE_W-1:0] ANGLE_TOP    = 16'sh7FFF;
   localparam logic signed [ANGLE_W-1:0] ANGLE_BOTTOM = 16'sh8000;
   // just inside and just past pi/2 in Q3.13, where the half-turn fold kicks in
   localparam logic signed [ANGLE_W-1:0] ANGLE_QTR_IN  = 16'sd12867;
   localparam logic signed [ANGLE_W-1:0] ANGLE_QTR_OUT = 16'sd12868;
   localparam logic signed [ANGLE_W-1:0] ANGLE_HALF    = 16'sd25736;
   localparam logic signed [ANGLE_W-1:0] ANGLE_EIGHTH  = 16'sd6434;
   localparam logic [RAD_W-1:0]          RADIUS_TOP    = 16'hFFFF;
   localparam logic signed [HD_W-1:0]    HD_TOP        = 16'sh7FFF;
   localparam logic signed [HD_W-1:0]    HD_BOTTOM     = 16'sh8000;

   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic signed [ANGLE_W-1:0] ang;
      logic [RAD_W-1:0]          rh;
      logic [RAD_W-1:0]          rl;
      logic signed [HD_W-1:0]    hd;
      logic                      hi;
   } ring_req_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_center_x;
   logic signed [COORD_W-1:0] req_center_y;
   logic signed [COORD_W-1:0] req_center_z;
   logic signed [ANGLE_W-1:0] req_facing_angle;
   logic [RAD_W-1:0]          req_high_radius;
   logic [RAD_W-1:0]          req_low_radius;
   logic signed [HD_W-1:0]    req_height_difference;
   logic                      req_facing_is_high;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [IDX_W-1:0]          rsp_armor_index;
   logic signed [COORD_W-1:0] rsp_armor_x;
   logic signed [COORD_W-1:0] rsp_armor_y;
   logic signed [COORD_W-1:0] rsp_armor_z;
   logic                      rsp_last_armor;

   int   mismatches;
   int   outstanding;
   int   armors_checked;
   int   clamped_coords;
   int   reqs_sent;
   int   holds_done;
   logic hold_request = 1'b0;

   armor_ring_positions u_dut (.*);

   armor_ring_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic ring_req_type make_req(input logic signed [COORD_W-1:0] cx,
                                             input logic signed [COORD_W-1:0] cy,
                                             input logic signed [COORD_W-1:0] cz,
                                             input logic signed [ANGLE_W-1:0] ang,
                                             input logic [RAD_W-1:0] rh,
                                             input logic [RAD_W-1:0] rl,
                                             input logic signed [HD_W-1:0] hd,
                                             input logic hi);
      ring_req_type r;
      r.cx = cx; r.cy = cy; r.cz = cz; r.ang = ang;
      r.rh = rh; r.rl = rl; r.hd = hd; r.hi = hi;
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] near_edge_coord();
      int off;
      off = $urandom_range(0, 70000);
      return $urandom_range(0, 1) ? COORD_W'(COORD_TOP - off) : COORD_W'(COORD_BOTTOM + off);
   endfunction

   function automatic ring_req_type random_req();
      ring_req_type r;
      if ($urandom_range(0, 4) == 0) begin
         r.cx = near_edge_coord();
         r.cy = near_edge_coord();
         r.cz = near_edge_coord();
      end else begin
         r.cx = COORD_W'($urandom);
         r.cy = COORD_W'($urandom);
         r.cz = COORD_W'($urandom);
      end
      if ($urandom_range(0, 7) == 0)
         r.ang = ANGLE_W'(($urandom_range(0, 1) ? 1 : -1) *
                          (ANGLE_QTR_OUT + $urandom_range(0, 4) - 2));
      else
         r.ang = ANGLE_W'($urandom);
      r.rh = ($urandom_range(0, 5) == 0) ? RAD_W'($urandom_range(0, 1023)) : RAD_W'($urandom);
      r.rl = ($urandom_range(0, 5) == 0) ? RAD_W'($urandom_range(0, 1023)) : RAD_W'($urandom);
      r.hd = HD_W'($urandom);
      r.hi = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // mostly back to back or short, now and then a long gap
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic drive_fields(input ring_req_type r);
      req_center_x          <= r.cx;
      req_center_y          <= r.cy;
      req_center_z          <= r.cz;
      req_facing_angle      <= r.ang;
      req_high_radius       <= r.rh;
      req_low_radius        <= r.rl;
      req_height_difference <= r.hd;
      req_facing_is_high    <= r.hi;
   endtask

   // returns just after the edge that takes the item
   task automatic offer(input ring_req_type r);
      @(negedge clock);
      drive_fields(r);
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      reqs_sent++;
   endtask

   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
         drive_fields(random_req());   // junk while not valid
      end
   endtask

   // receiver side: random stall runs, plus a long hold-off on request
   initial begin
      int   hold_left;
      int   run_left;
      logic run_stall;
      int   roll;
      rsp_stall  = 1'b0;
      hold_left  = 0;
      run_left   = 0;
      run_stall  = 1'b0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            holds_done++;
         end
         if (run_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               run_stall = 1'b0;
               run_left  = $urandom_range(1, 8);
            end else if (roll < 60) begin
               run_stall = 1'b0;
               run_left  = $urandom_range(30, 80);
            end else if (roll < 90) begin
               run_stall = 1'b1;
               run_left  = $urandom_range(1, 3);
            end else begin
               run_stall = 1'b1;
               run_left  = $urandom_range(10, 40);
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= run_stall;
            run_left--;
         end
      end
   end

   initial begin
      ring_req_type directed [$];
      int           burst_left;
      reset     = 1'b1;
      req_valid = 1'b0;
      reqs_sent = 0;
      drive_fields(make_req(0, 0, 0, 0, 0, 0, 0, 1'b0));
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 1'b0));
      directed.push_back(make_req(256, 512, -256, 0, 16'h0100, 16'h0200, 16'sh0080, 1'b1));
      directed.push_back(make_req(1000, 0, -1000, ANGLE_TOP, RADIUS_TOP, RADIUS_TOP, 0, 1'b1));
      directed.push_back(make_req(-1000, 0, 1000, ANGLE_BOTTOM, RADIUS_TOP, RADIUS_TOP, 0,
                                  1'b0));
      directed.push_back(make_req(0, 0, 0, ANGLE_QTR_IN, 16'h1234, 16'h4321, 16'sh0100, 1'b1));
      directed.push_back(make_req(0, 0, 0, ANGLE_QTR_OUT, 16'h1234, 16'h4321, 16'sh0100, 1'b0));
      directed.push_back(make_req(0, 0, 0, -ANGLE_QTR_IN, 16'h1234, 16'h4321, -16'sh0100,
                                  1'b1));
      directed.push_back(make_req(0, 0, 0, -ANGLE_QTR_OUT, 16'h1234, 16'h4321, -16'sh0100,
                                  1'b0));
      directed.push_back(make_req(5000, 5000, 5000, ANGLE_HALF, RADIUS_TOP, 16'h0800, 0, 1'b1));
      directed.push_back(make_req(5000, 5000, 5000, -ANGLE_HALF, RADIUS_TOP, 16'h0800, 0,
                                  1'b0));
      directed.push_back(make_req(0, 0, 0, ANGLE_EIGHTH, RADIUS_TOP, RADIUS_TOP, 0, 1'b1));
      directed.push_back(make_req(0, 0, 0, 1, RADIUS_TOP, 16'h0001, 0, 1'b1));
      directed.push_back(make_req(0, 0, 0, -1, RADIUS_TOP, 16'h0001, 0, 1'b0));
      // centres at the rails push armors past the coordinate range
      directed.push_back(make_req(COORD_TOP, COORD_TOP, COORD_TOP, ANGLE_EIGHTH, RADIUS_TOP,
                                  RADIUS_TOP, 0, 1'b1));
      directed.push_back(make_req(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, -ANGLE_EIGHTH,
                                  RADIUS_TOP, RADIUS_TOP, 0, 1'b0));
      directed.push_back(make_req(COORD_TOP, COORD_BOTTOM, COORD_BOTTOM,
                                  ANGLE_W'(-3 * ANGLE_EIGHTH), RADIUS_TOP, RADIUS_TOP,
                                  HD_TOP, 1'b1));
      directed.push_back(make_req(COORD_BOTTOM, COORD_TOP, COORD_TOP,
                                  ANGLE_W'(3 * ANGLE_EIGHTH), RADIUS_TOP, RADIUS_TOP,
                                  HD_BOTTOM, 1'b0));
      directed.push_back(make_req(0, COORD_TOP, 0, 0, 0, 0, HD_BOTTOM, 1'b1));
      directed.push_back(make_req(0, COORD_BOTTOM, 0, 0, 0, 0, HD_TOP, 1'b0));
      directed.push_back(make_req(-7, 3, 9, ANGLE_QTR_OUT, RADIUS_TOP, 0, 16'sh0200, 1'b1));
      directed.push_back(make_req(-7, 3, 9, ANGLE_QTR_OUT, RADIUS_TOP, 0, 16'sh0200, 1'b0));
      foreach (directed[i]) begin
         offer(directed[i]);
         idle_for(gap_length());
      end

      burst_left = 0;
      for (int n = 0; n < RANDOM_REQS; n++) begin
         offer(random_req());
         if (n == 100 || n == 220) begin
            // receiver holds off while items keep coming, so the pipe backs up
            hold_request = 1'b1;
            burst_left   = BURST_REQS;
         end else if (burst_left > 0) begin
            burst_left--;
         end else if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(10, 30);
         end else begin
            idle_for(gap_length());
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (2 * PIPE_LATENCY) @(posedge clock);

      $display("Covered %0d requests: half-turn fold edges, full angle span, zero and full radii.",
               reqs_sent);
      $display("%0d armors compared, %0d clamped coordinates, %0d long hold-offs, %0d mismatches.",
               armors_checked, clamped_coords, holds_done, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== armor_ring_positions.f =====
rtl/arp_pkg.sv
rtl/arp_cordic_stage.sv
rtl/arp_scale.sv
rtl/arp_serializer.sv
rtl/armor_ring_positions.sv
sim/armor_ring_checker.sv
sim/tb_armor_ring_positions.sv
